### hw/rtl/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

  // Geometry of the plane chain
  localparam int NUM_PLANES = 6;
  localparam int COORD_BITS = 32;

  // Item kinds carried on the func field
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  // Visibility classes
  localparam logic [1:0] VIS_NONE = 2'd0;
  localparam logic [1:0] VIS_PART = 2'd1;
  localparam logic [1:0] VIS_FULL = 2'd2;

  // One beat travelling down the chain. For a load, a/b/c/w carry the
  // normal and offset; for a test, the center and the radius.
  typedef struct packed {
    logic        vld;
    logic        func;
    logic [2:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] w;
    logic        culled;
    logic        partial;
  } beat_t;

  // Take the low COORD_BITS bits of a coordinate as two's complement
  function automatic logic signed [31:0] sext_coord(input logic [31:0] v);
    logic signed [31:0] s;
    s = signed'(v << (32 - COORD_BITS));
    return s >>> (32 - COORD_BITS);
  endfunction

  // Keep the low COORD_BITS-1 bits of the radius
  function automatic logic [30:0] mask_radius(input logic [31:0] v);
    logic [31:0] m;
    m = (32'd1 << (COORD_BITS - 1)) - 32'd1;
    return 31'(v & m);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sfc_cell.sv
`default_nettype none

module sfc_cell import sfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic [2:0] cell_id,
  input  wire beat_t      beat_i,
  output beat_t           beat_o
);

  // Plane held by this cell
  logic [31:0] nx, ny, nz, pd;

  // Internal stages: input, products, pair sums, distance
  beat_t s1, s2, s3, s4;

  logic signed [63:0] px, py, pz;
  logic signed [47:0] pdq;
  logic signed [64:0] sa, sb;
  logic signed [65:0] distance;

  logic signed [66:0] rq, lp, lm;
  logic               cull_hit, short_hit;

  // Write the plane when a load for this cell enters
  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= '0;
      ny <= '0;
      nz <= '0;
      pd <= '0;
    end else if (adv && beat_i.vld && beat_i.func == FUNC_LOAD && beat_i.idx == cell_id) begin
      nx <= beat_i.a;
      ny <= beat_i.b;
      nz <= beat_i.c;
      pd <= beat_i.w;
    end
  end

  // Advance the beat through the cell stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else if (adv) begin
      s1 <= beat_i;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
    end
  end

  // Form the products, then the pair sums, then the distance
  always_ff @(posedge clk) begin
    if (adv) begin
      px       <= sext_coord(s1.a) * sext_coord(nx);
      py       <= sext_coord(s1.b) * sext_coord(ny);
      pz       <= sext_coord(s1.c) * sext_coord(nz);
      pdq      <= signed'({sext_coord(pd), 16'h0000});
      sa       <= 65'(px) + 65'(py);
      sb       <= 65'(pz) + 65'(pdq);
      distance <= 66'(sa) + 66'(sb);
    end
  end

  // Compare the distance against plus and minus the radius
  assign rq        = signed'({20'd0, mask_radius(s4.w), 16'h0000});
  assign lp        = 67'(distance) + rq;
  assign lm        = 67'(distance) - rq;
  assign cull_hit  = lp[66] || (lp == '0);
  assign short_hit = lm[66];

  // Fold this plane's verdict into the beat
  always_comb begin
    beat_o = s4;
    if (s4.vld && s4.func == FUNC_TEST && !s4.culled) begin
      if (cull_hit) begin
        beat_o.culled = 1'b1;
      end else if (short_hit) begin
        beat_o.partial = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sphere_frustum_classifier.sv
// An accepted beat passes through every plane cell and then the output register to its result.
// Throughput: one beat per cycle; the chain of plane cells, four stages each, moves as one
// and freezes while a waiting result is stalled.
// Reset: all planes read as zero, the chain and the output register are emptied.
`default_nettype none

module sphere_frustum_classifier import sfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [2:0]  plane_index,
  input  wire logic [31:0] normal_x,
  input  wire logic [31:0] normal_y,
  input  wire logic [31:0] normal_z,
  input  wire logic [31:0] plane_offset,
  input  wire logic [31:0] center_x,
  input  wire logic [31:0] center_y,
  input  wire logic [31:0] center_z,
  input  wire logic [30:0] radius,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       visibility,
  output logic             any_visible
);

  logic  adv;
  beat_t chain [NUM_PLANES+1];
  beat_t tail;
  logic [1:0] vis_next;

  // Move the whole chain whenever the output register can take a beat
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Pack the incoming beat
  always_comb begin
    chain[0].vld     = in_valid;
    chain[0].func    = func;
    chain[0].idx     = plane_index;
    chain[0].culled  = 1'b0;
    chain[0].partial = 1'b0;
    if (func == FUNC_LOAD) begin
      chain[0].a = normal_x;
      chain[0].b = normal_y;
      chain[0].c = normal_z;
      chain[0].w = plane_offset;
    end else begin
      chain[0].a = center_x;
      chain[0].b = center_y;
      chain[0].c = center_z;
      chain[0].w = {1'b0, radius};
    end
  end

  // One cell per plane
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    sfc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .cell_id (3'(i)),
      .beat_i  (chain[i]),
      .beat_o  (chain[i+1])
    );
  end

  assign tail = chain[NUM_PLANES];

  // Classify the beat leaving the last cell
  always_comb begin
    if (tail.culled) begin
      vis_next = VIS_NONE;
    end else if (tail.partial) begin
      vis_next = VIS_PART;
    end else begin
      vis_next = VIS_FULL;
    end
  end

  // Output register: only tests give a result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tail.vld && tail.func == FUNC_TEST;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      visibility  <= vis_next;
      any_visible <= !tail.culled;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sfc_checker.sv
`default_nettype none

module sfc_checker import sfc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] visibility,
  input wire logic       any_visible
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(visibility) && $stable(any_visible))
    else $error("stalled result beat changed");

  // Keep the summary flag consistent with the class
  a_any_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> any_visible == (visibility != VIS_NONE))
    else $error("any_visible disagrees with visibility");

  // Never report the unused class code
  a_vis_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (visibility == VIS_NONE || visibility == VIS_PART || visibility == VIS_FULL))
    else $error("visibility outside its classes");

  // Back-pressure the input while a result waits
  a_backpress: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled behind a blocked result");

  // Come out of reset with no result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sphere_frustum_classifier sfc_checker u_sfc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .visibility  (visibility),
  .any_visible (any_visible)
);

`default_nettype wire
